@@ design/lofc_pkg.sv @@
// ----------------------------------------------------------------------------
// lofc_pkg
// Shared types, codes and reset values for the lamp output flasher controller.
// ----------------------------------------------------------------------------
package lofc_pkg;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_FRAME   = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_TICK    = 2'd2
  } lofc_func_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FLASH_ON  = 2'd0;
  localparam logic [1:0] CFG_FLASH_OFF = 2'd1;
  localparam logic [1:0] CFG_PGN_EXT   = 2'd2;
  localparam logic [1:0] CFG_PGN_LOC   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [7:0]  FLASH_ON_RST  = 8'd3;
  localparam logic [7:0]  FLASH_OFF_RST = 8'd3;
  localparam logic [15:0] PGN_EXT_RST   = 16'd44800;
  localparam logic [15:0] PGN_LOC_RST   = 16'd65280;

  // Lamp bit positions (bit 0 is output one).
  localparam int LAMP_LEFT     = 0;
  localparam int LAMP_RIGHT    = 1;
  localparam int LAMP_HIGH     = 2;
  localparam int LAMP_PARKING  = 3;
  localparam int LAMP_IGNITION = 4;
  localparam int LAMP_SECURITY = 5;
  localparam int LAMP_AUX7     = 6;
  localparam int LAMP_AUX8     = 7;

  // Input request payload.
  typedef struct packed {
    logic [1:0]  func;
    logic [28:0] frame_id;
    logic [7:0]  cmd_byte;
    logic [7:0]  aux_byte;
    logic        ignition_line;
    logic        left_line;
    logic        right_line;
    logic        parking_line;
    logic        high_beam_line;
    logic        hazard_line;
    logic        ignition_status;
  } lofc_in_t;

  // Result request payload.
  typedef struct packed {
    logic [7:0] lamp_states;
    logic       frame_accepted;
    logic       report_valid;
    logic       report_ignition;
    logic       report_security;
  } lofc_out_t;

  // Flasher state.
  typedef struct packed {
    logic       phase;
    logic [7:0] count;
  } lofc_flash_t;

endpackage

@@ design/lofc_in_stage.sv @@
// ----------------------------------------------------------------------------
// lofc_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lofc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lofc_pkg::lofc_in_t in_data,
  output logic               s_valid,
  output lofc_pkg::lofc_in_t s_data,
  input  logic               s_take
);
  import lofc_pkg::*;

  logic     valid_r;
  lofc_in_t data_r;

  // Accept a new request when empty or when the held one leaves in this cycle.
  assign in_ready = !valid_r || s_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign s_valid = valid_r;
  assign s_data  = data_r;

endmodule

@@ design/lofc_core.sv @@
// ----------------------------------------------------------------------------
// lofc_core
// Configuration registers, lamp state and flashers, and the per-request update.
// ----------------------------------------------------------------------------
module lofc_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lofc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lofc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                item_fire,
  input  lofc_pkg::lofc_in_t                  item,
  output lofc_pkg::lofc_out_t                 result
);
  import lofc_pkg::*;

  logic [7:0]  flash_on_r;
  logic [7:0]  flash_off_r;
  logic [15:0] pgn_ext_r;
  logic [15:0] pgn_loc_r;

  logic [7:0]  lamp_r, lamp_nxt;
  logic [5:0]  ovr_r, ovr_nxt;
  logic        sec_r, sec_nxt;
  lofc_flash_t left_r, left_nxt;
  lofc_flash_t right_r, right_nxt;

  logic [15:0] pgn;
  logic        ext_hit;
  logic        loc_hit;
  logic        left_act;
  logic        right_act;

  // One flasher step: clear when inactive, else count down, then toggle phase and reload.
  function automatic lofc_flash_t flash_step(input lofc_flash_t cur, input logic act,
                                             input logic [7:0] on_len,
                                             input logic [7:0] off_len);
    lofc_flash_t n;
    n = cur;
    if (!act) begin
      n.phase = 1'b0;
      n.count = 8'd0;
    end else if (cur.count != 8'd0) begin
      n.count = cur.count - 8'd1;
    end else if (cur.phase) begin
      n.phase = 1'b0;
      n.count = off_len - 8'd1;
    end else begin
      n.phase = 1'b1;
      n.count = on_len - 8'd1;
    end
    return n;
  endfunction

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_on_r  <= FLASH_ON_RST;
      flash_off_r <= FLASH_OFF_RST;
      pgn_ext_r   <= PGN_EXT_RST;
      pgn_loc_r   <= PGN_LOC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLASH_ON:  flash_on_r  <= cfg_wdata[7:0];
        CFG_FLASH_OFF: flash_off_r <= cfg_wdata[7:0];
        CFG_PGN_EXT:   pgn_ext_r   <= cfg_wdata;
        CFG_PGN_LOC:   pgn_loc_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pgn       = item.frame_id[23:8];
  assign ext_hit   = (pgn == pgn_ext_r);
  assign loc_hit   = (pgn == pgn_loc_r);
  assign left_act  = (item.left_line && item.ignition_status) || item.hazard_line;
  assign right_act = (item.right_line && item.ignition_status) || item.hazard_line;

  // Next state and result for the request at the head of the input register.
  always_comb begin
    lamp_nxt  = lamp_r;
    ovr_nxt   = ovr_r;
    sec_nxt   = sec_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    result    = '0;
    case (item.func)
      FUNC_FRAME: begin
        if (ext_hit || loc_hit) begin
          result.frame_accepted = 1'b1;
          ovr_nxt               = item.cmd_byte[5:0];
          lamp_nxt[LAMP_AUX7]   = item.cmd_byte[6];
          lamp_nxt[LAMP_AUX8]   = item.cmd_byte[7];
          if (ext_hit) begin
            result.report_valid     = 1'b1;
            result.report_ignition  = item.aux_byte[0];
            result.report_security  = item.aux_byte[1];
            sec_nxt                 = item.aux_byte[1];
            lamp_nxt[LAMP_SECURITY] = item.aux_byte[1];
          end
        end
      end
      FUNC_REFRESH: begin
        lamp_nxt[LAMP_HIGH]     = (item.high_beam_line && item.ignition_status) || ovr_r[2];
        lamp_nxt[LAMP_PARKING]  = item.parking_line || ovr_r[3];
        lamp_nxt[LAMP_IGNITION] = item.ignition_line || ovr_r[4];
        lamp_nxt[LAMP_SECURITY] = sec_r || ovr_r[5];
      end
      FUNC_TICK: begin
        left_nxt             = flash_step(left_r, left_act, flash_on_r, flash_off_r);
        right_nxt            = flash_step(right_r, right_act, flash_on_r, flash_off_r);
        lamp_nxt[LAMP_LEFT]  = left_nxt.phase || ovr_r[0];
        lamp_nxt[LAMP_RIGHT] = right_nxt.phase || ovr_r[1];
      end
      default: ;
    endcase
    result.lamp_states = lamp_nxt;
  end

  // State advances only when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r  <= '0;
      ovr_r   <= '0;
      sec_r   <= 1'b0;
      left_r  <= '0;
      right_r <= '0;
    end else if (item_fire) begin
      lamp_r  <= lamp_nxt;
      ovr_r   <= ovr_nxt;
      sec_r   <= sec_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

@@ design/lofc_out_stage.sv @@
// ----------------------------------------------------------------------------
// lofc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lofc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_valid,
  output logic                load_ok,
  input  lofc_pkg::lofc_out_t load_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lofc_pkg::lofc_out_t out_data
);
  import lofc_pkg::*;

  logic      valid_r;
  lofc_out_t data_r;

  // The register can load when empty or when its result leaves this cycle.
  assign load_ok = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ok) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ design/lamp_output_flasher_controller.sv @@
// ----------------------------------------------------------------------------
// lamp_output_flasher_controller
// Eight-output lamp controller with command frames, input refresh and flashers.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output is not stalled,
// and returns one result for each. The request is held in an input register,
// the lamp state, overrides and both flashers are updated by a single pass of
// logic, and the result is held in an output register. The result is loaded
// into the output register when the request leaves the input register. Both
// registers keep flowing while the next stage takes data, so throughput is one
// request per cycle under no backpressure. Configuration writes take effect at
// the next edge and are expected only while no request is in flight.
// ----------------------------------------------------------------------------
module lamp_output_flasher_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lofc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lofc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lofc_pkg::lofc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lofc_pkg::lofc_out_t             out_data
);
  import lofc_pkg::*;

  logic      s_valid;
  lofc_in_t  s_data;
  logic      load_ok;
  logic      s_take;
  lofc_out_t result;

  // A request moves forward when the result register can load.
  assign s_take = s_valid && load_ok;

  lofc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_data   (s_data),
    .s_take   (s_take)
  );

  lofc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_fire (s_take),
    .item      (s_data),
    .result    (result)
  );

  lofc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s_valid),
    .load_ok    (load_ok),
    .load_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
